>>> sv/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/trplru_pkg.sv
package trplru_pkg;

    localparam int DEF_SET_COUNT = 64;
    localparam int DEF_WAY_COUNT = 8;
    localparam int DEF_TAG_BITS  = 20;

    localparam int SET_IDX_W = 6;
    localparam int TAG_IN_W  = 20;
    localparam int WAY_OUT_W = 3;

    typedef enum logic [1:0] {
        FN_ACCESS = 2'd0,
        FN_INSERT = 2'd1,
        FN_EVICT  = 2'd2,
        FN_PEEK   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_MISS  = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        t_func                 func;
        logic [SET_IDX_W-1:0]  set_index;
        logic [TAG_IN_W-1:0]   tag_value;
    } t_req;

    typedef struct packed {
        t_status               status;
        logic [TAG_IN_W-1:0]   victim_tag;
        logic [WAY_OUT_W-1:0]  way_used;
    } t_res;

    typedef struct packed {
        logic accept;
        logic fire;
        logic clearing;
    } t_ctl;

endpackage

>>> sv/trplru_ram.sv
module trplru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/trplru_ctrl.sv
module trplru_ctrl
    import trplru_pkg::*;
#(
    parameter int SET_COUNT = DEF_SET_COUNT,
    parameter int SA_W      = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    input  logic            i_res_free,
    output logic            o_req_ready,
    output t_ctl            o_ctl,
    output logic [SA_W-1:0] o_clr_addr
);

    t_state          r_state;
    t_state          n_state;
    logic [SA_W-1:0] r_clr_addr;
    logic [SA_W-1:0] n_clr_addr;
    logic            clr_last;

    assign clr_last = (r_clr_addr == SA_W'(SET_COUNT - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        case (r_state)
            S_CLEAR: begin
                n_clr_addr = r_clr_addr + 1'b1;
                if (clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_res_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_req_ready    = 1'b0;
        o_ctl.accept   = 1'b0;
        o_ctl.fire     = 1'b0;
        o_ctl.clearing = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_ctl.clearing = 1'b1;
            end
            S_IDLE: begin
                o_req_ready  = 1'b1;
                o_ctl.accept = i_req_valid;
            end
            S_EXEC: begin
                o_ctl.fire = i_res_free;
            end
            default: begin
                o_req_ready = 1'b0;
            end
        endcase
    end

    assign o_clr_addr = r_clr_addr;

endmodule

>>> sv/trplru_dp.sv
module trplru_dp
    import trplru_pkg::*;
#(
    parameter int WAY_COUNT = DEF_WAY_COUNT,
    parameter int TAG_BITS  = DEF_TAG_BITS,
    parameter int WI_W      = $clog2(WAY_COUNT),
    parameter int META_W    = 2 * WAY_COUNT - 1
) (
    input  t_func                         i_func,
    input  logic [TAG_BITS-1:0]           i_tag,
    input  logic [META_W-1:0]             i_meta,
    input  logic [WAY_COUNT*TAG_BITS-1:0] i_tags,
    output logic [META_W-1:0]             o_meta,
    output logic [WAY_COUNT*TAG_BITS-1:0] o_tags,
    output logic                          o_tag_we,
    output t_status                       o_status,
    output logic [TAG_BITS-1:0]           o_vtag,
    output logic [WI_W-1:0]               o_way
);

    localparam int TREE_W = WAY_COUNT - 1;
    localparam int NODE_W = $clog2(2 * WAY_COUNT);
    localparam int LVLS   = $clog2(WAY_COUNT);

    // Heap-ordered tree: node n has children 2n+1 and 2n+2, way w is leaf WAY_COUNT-1+w.
    function automatic logic [TREE_W-1:0] f_touch(input logic [TREE_W-1:0] t,
                                                   input logic [WI_W-1:0]   w);
        logic [NODE_W-1:0] node;
        logic [NODE_W-1:0] parent;
        logic [TREE_W-1:0] r;
        r    = t;
        node = NODE_W'(WAY_COUNT - 1) + NODE_W'(w);
        for (int k = 0; k < LVLS; k++) begin
            if (node != '0) begin
                parent = (node - 1'b1) >> 1;
                // A left child makes its parent point right, and the other way round.
                if (node[0]) begin
                    r = r | (TREE_W'(1) << parent);
                end else begin
                    r = r & ~(TREE_W'(1) << parent);
                end
                node = parent;
            end
        end
        return r;
    endfunction

    function automatic logic [WI_W-1:0] f_walk(input logic [TREE_W-1:0] t);
        logic [NODE_W-1:0] node;
        logic [TREE_W-1:0] sel;
        node = '0;
        for (int k = 0; k < LVLS; k++) begin
            if (node < NODE_W'(WAY_COUNT - 1)) begin
                sel  = t >> node;
                node = sel[0] ? (node << 1) + NODE_W'(2) : (node << 1) + NODE_W'(1);
            end
        end
        return WI_W'(node - NODE_W'(WAY_COUNT - 1));
    endfunction

    function automatic logic [WI_W-1:0] f_lowest(input logic [WAY_COUNT-1:0] v);
        logic [WI_W-1:0] r;
        r = '0;
        for (int w = WAY_COUNT - 1; w >= 0; w--) begin
            if (v[w]) begin
                r = WI_W'(w);
            end
        end
        return r;
    endfunction

    logic [TREE_W-1:0]                   tree;
    logic [WAY_COUNT-1:0]                valid;
    logic [WAY_COUNT-1:0][TAG_BITS-1:0]  tag_row;
    logic [WAY_COUNT-1:0][TAG_BITS-1:0]  tag_row_new;
    logic [WAY_COUNT-1:0]                hit;
    logic [WAY_COUNT-1:0]                free_onehot;
    logic [WI_W-1:0]                     hit_way;
    logic [WI_W-1:0]                     free_way;
    logic [WI_W-1:0]                     ins_touch_way;
    logic [WI_W-1:0]                     vic_way;
    logic                                vic_valid;
    logic [TREE_W-1:0]                   n_tree;
    logic [WAY_COUNT-1:0]                n_valid;

    assign tree    = i_meta[TREE_W-1:0];
    assign valid   = i_meta[META_W-1:TREE_W];
    assign tag_row = i_tags;

    always_comb begin
        for (int w = 0; w < WAY_COUNT; w++) begin
            hit[w] = valid[w] && (tag_row[w] == i_tag);
        end
    end

    assign hit_way     = f_lowest(hit);
    assign free_way    = f_lowest(~valid);
    assign free_onehot = WAY_COUNT'(1) << free_way;
    // The new way also matches, so a duplicate insert touches the lower-numbered copy.
    assign ins_touch_way = f_lowest(hit | free_onehot);
    assign vic_way       = f_walk(tree);
    assign vic_valid     = valid[vic_way];

    always_comb begin
        tag_row_new           = tag_row;
        tag_row_new[free_way] = i_tag;
    end

    always_comb begin
        n_tree   = tree;
        n_valid  = valid;
        o_tag_we = 1'b0;
        o_status = ST_OK;
        o_vtag   = '0;
        o_way    = '0;
        case (i_func)
            FN_ACCESS: begin
                if (|hit) begin
                    n_tree = f_touch(tree, hit_way);
                    o_way  = hit_way;
                end else begin
                    o_status = ST_MISS;
                end
            end
            FN_INSERT: begin
                if (&valid) begin
                    o_status = ST_FULL;
                end else begin
                    n_valid  = valid | free_onehot;
                    n_tree   = f_touch(tree, ins_touch_way);
                    o_tag_we = 1'b1;
                    o_way    = free_way;
                end
            end
            FN_EVICT, FN_PEEK: begin
                o_way = vic_way;
                if (vic_valid) begin
                    o_vtag = tag_row[vic_way];
                    if (i_func == FN_EVICT) begin
                        n_valid = valid & ~(WAY_COUNT'(1) << vic_way);
                    end
                end else begin
                    o_status = ST_EMPTY;
                end
            end
            default: begin
                o_status = ST_OK;
            end
        endcase
    end

    assign o_meta = {n_valid, n_tree};
    assign o_tags = tag_row_new;

endmodule

>>> sv/tree_plru_replacement.sv
// Channel   Direction  Handshake                   Payload
// request   in         i_req_valid / o_req_ready   i_req (t_req)
// result    out        o_res_valid / i_res_ready   o_res (t_res)
//
// The set's tree/valid row and tag row are read on acceptance of a request and
// modified and written back in the execute state that follows.
// After reset a clearing pass over all SET_COUNT sets zeroes the tree/valid memory;
// o_req_ready stays low during it. Tag memory is not cleared.
// A finished result sits in an output register; a new request is accepted while
// it waits, and the write-back cycle holds until that register is free.
module tree_plru_replacement
    import trplru_pkg::*;
#(
    parameter int SET_COUNT = DEF_SET_COUNT,
    parameter int WAY_COUNT = DEF_WAY_COUNT,
    parameter int TAG_BITS  = DEF_TAG_BITS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_req i_req,
    output logic o_res_valid,
    input  logic i_res_ready,
    output t_res o_res
);

`include "assert_macros.svh"

    localparam int SA_W   = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
    localparam int WI_W   = $clog2(WAY_COUNT);
    localparam int META_W = 2 * WAY_COUNT - 1;
    localparam int TROW_W = WAY_COUNT * TAG_BITS;

    t_ctl                        ctl;
    logic [SA_W-1:0]             clr_addr;
    logic                        res_free;
    logic [SA_W-1:0]             set_tab [2**SET_IDX_W];
    logic [SA_W-1:0]             set_in;
    logic [TAG_BITS+TAG_IN_W-1:0] tag_ext;
    logic [TAG_BITS-1:0]         tag_in;

    t_func                       r_func;
    logic [SA_W-1:0]             r_set;
    logic [TAG_BITS-1:0]         r_tag;

    logic                        meta_we;
    logic [SA_W-1:0]             meta_waddr;
    logic [META_W-1:0]           meta_wdata;
    logic [META_W-1:0]           meta_rdata;
    logic [META_W-1:0]           dp_meta;
    logic [TROW_W-1:0]           tags_rdata;
    logic [TROW_W-1:0]           dp_tags;
    logic                        dp_tag_we;
    logic                        tag_we;
    t_status                     dp_status;
    logic [TAG_BITS-1:0]         dp_vtag;
    logic [WI_W-1:0]             dp_way;
    logic [TAG_BITS+TAG_IN_W-1:0] vtag_ext;
    logic [WI_W+WAY_OUT_W-1:0]   way_ext;

    t_res                        n_res;
    t_res                        r_res;
    logic                        r_res_valid;

    // Set index reduced modulo SET_COUNT through a constant table.
    for (genvar g = 0; g < 2**SET_IDX_W; g++) begin : g_set_tab
        localparam int SetMod = g % SET_COUNT;
        assign set_tab[g] = SA_W'(SetMod);
    end

    assign set_in  = set_tab[i_req.set_index];
    assign tag_ext = {{TAG_BITS{1'b0}}, i_req.tag_value};
    assign tag_in  = tag_ext[TAG_BITS-1:0];

    assign res_free = !r_res_valid || i_res_ready;

    trplru_ctrl #(
        .SET_COUNT (SET_COUNT),
        .SA_W      (SA_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .i_res_free  (res_free),
        .o_req_ready (o_req_ready),
        .o_ctl       (ctl),
        .o_clr_addr  (clr_addr)
    );

    always_ff @(posedge i_clk) begin
        if (ctl.accept) begin
            r_func <= i_req.func;
            r_set  <= set_in;
            r_tag  <= tag_in;
        end
    end

    assign meta_we    = ctl.clearing || ctl.fire;
    assign meta_waddr = ctl.clearing ? clr_addr : r_set;
    assign meta_wdata = ctl.clearing ? '0 : dp_meta;
    assign tag_we     = ctl.fire && dp_tag_we;

    trplru_ram #(
        .WIDTH (META_W),
        .DEPTH (SET_COUNT),
        .AW    (SA_W)
    ) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (meta_we),
        .i_waddr (meta_waddr),
        .i_wdata (meta_wdata),
        .i_re    (ctl.accept),
        .i_raddr (set_in),
        .o_rdata (meta_rdata)
    );

    trplru_ram #(
        .WIDTH (TROW_W),
        .DEPTH (SET_COUNT),
        .AW    (SA_W)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (tag_we),
        .i_waddr (r_set),
        .i_wdata (dp_tags),
        .i_re    (ctl.accept),
        .i_raddr (set_in),
        .o_rdata (tags_rdata)
    );

    trplru_dp #(
        .WAY_COUNT (WAY_COUNT),
        .TAG_BITS  (TAG_BITS),
        .WI_W      (WI_W),
        .META_W    (META_W)
    ) u_dp (
        .i_func   (r_func),
        .i_tag    (r_tag),
        .i_meta   (meta_rdata),
        .i_tags   (tags_rdata),
        .o_meta   (dp_meta),
        .o_tags   (dp_tags),
        .o_tag_we (dp_tag_we),
        .o_status (dp_status),
        .o_vtag   (dp_vtag),
        .o_way    (dp_way)
    );

    assign vtag_ext = {{TAG_IN_W{1'b0}}, dp_vtag};
    assign way_ext  = {{WAY_OUT_W{1'b0}}, dp_way};

    always_comb begin
        n_res.status     = dp_status;
        n_res.victim_tag = vtag_ext[TAG_IN_W-1:0];
        n_res.way_used   = way_ext[WAY_OUT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (ctl.fire) begin
            r_res_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.fire) begin
            r_res <= n_res;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    `ASSERT_IMPL(a_no_req_while_clearing, i_clk, i_rst_n, ctl.clearing, !o_req_ready,
                 "request taken during clearing pass")
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, ctl.accept, !o_req_ready,
                 "second request taken before write-back of the set")
    `ASSERT_IMPL(a_tag_write_on_insert, i_clk, i_rst_n, tag_we,
                 (r_func == FN_INSERT) && (dp_status == ST_OK),
                 "tag row written outside a successful insert")
    `ASSERT_IMPL(a_full_set_unchanged, i_clk, i_rst_n, ctl.fire && (dp_status == ST_FULL),
                 dp_meta == meta_rdata, "rejected insert modified tree or valid bits")

endmodule

>>> test/plru_scoreboard_pkg.sv
package plru_scoreboard_pkg;
    import trplru_pkg::*;

    localparam int SETS = DEF_SET_COUNT;
    localparam int WAYS = DEF_WAY_COUNT;

    class plru_scoreboard;
        logic [WAYS-2:0]     tree_bits [SETS];
        logic [TAG_IN_W-1:0] way_tags  [SETS][WAYS];
        logic [WAYS-1:0]     way_valid [SETS];
        t_res                expected_results [$];
        int                  error_count;

        function new();
            for (int s = 0; s < SETS; s++) begin
                tree_bits[s] = '0;
                way_valid[s] = '0;
                for (int w = 0; w < WAYS; w++) begin
                    way_tags[s][w] = '0;
                end
            end
            error_count = 0;
        endfunction

        // Every node on the path to the way is turned to point at the other subtree.
        function void touch_way(int set, int way);
            int node;
            int parent;
            node = WAYS - 1 + way;
            while (node > 0) begin
                parent = (node - 1) / 2;
                tree_bits[set][parent] = (node == 2 * parent + 1);
                node = parent;
            end
        endfunction

        function int lowest_hit(int set, logic [TAG_IN_W-1:0] tag);
            for (int w = 0; w < WAYS; w++) begin
                if (way_valid[set][w] && way_tags[set][w] == tag) begin
                    return w;
                end
            end
            return -1;
        endfunction

        function int victim_way(int set);
            int node;
            node = 0;
            while (node < WAYS - 1) begin
                node = tree_bits[set][node] ? 2 * node + 2 : 2 * node + 1;
            end
            return node - (WAYS - 1);
        endfunction

        function t_res predict_outcome(t_req req);
            t_res res;
            int   set;
            int   w;
            int   hit;
            res        = '0;
            res.status = ST_OK;
            set        = int'(req.set_index) % SETS;
            case (req.func)
                FN_ACCESS: begin
                    hit = lowest_hit(set, req.tag_value);
                    if (hit < 0) begin
                        res.status = ST_MISS;
                    end else begin
                        touch_way(set, hit);
                        res.way_used = WAY_OUT_W'(hit);
                    end
                end
                FN_INSERT: begin
                    w = 0;
                    while (w < WAYS && way_valid[set][w]) begin
                        w++;
                    end
                    if (w == WAYS) begin
                        res.status = ST_FULL;
                    end else begin
                        way_tags[set][w]  = req.tag_value;
                        way_valid[set][w] = 1'b1;
                        // A duplicate tag touches the lowest-numbered copy, old or new.
                        hit = lowest_hit(set, req.tag_value);
                        touch_way(set, hit);
                        res.way_used = WAY_OUT_W'(w);
                    end
                end
                default: begin
                    w = victim_way(set);
                    res.way_used = WAY_OUT_W'(w);
                    if (!way_valid[set][w]) begin
                        res.status = ST_EMPTY;
                    end else begin
                        res.victim_tag = way_tags[set][w];
                        if (req.func == FN_EVICT) begin
                            way_valid[set][w] = 1'b0;
                        end
                    end
                end
            endcase
            return res;
        endfunction

        function void note_request(t_req req);
            expected_results = {expected_results, predict_outcome(req)};
        endfunction

        function void check_result(t_res got);
            t_res exp;
            if (expected_results.size() == 0) begin
                $error("unexpected result: status=%0d victim_tag=%h way_used=%0d",
                       got.status, got.victim_tag, got.way_used);
                error_count++;
                return;
            end
            exp = expected_results[0];
            expected_results.delete(0);
            if (got.status !== exp.status) begin
                $error("status: expected %0d, got %0d", exp.status, got.status);
                error_count++;
            end
            if (got.victim_tag !== exp.victim_tag) begin
                $error("victim_tag: expected %h, got %h", exp.victim_tag, got.victim_tag);
                error_count++;
            end
            if (got.way_used !== exp.way_used) begin
                $error("way_used: expected %0d, got %0d", exp.way_used, got.way_used);
                error_count++;
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

endpackage

>>> test/tb_tree_plru_replacement.sv
module tb_tree_plru_replacement
    import trplru_pkg::*;
    import plru_scoreboard_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_req_valid = 1'b0;
    logic i_res_ready = 1'b0;
    t_req i_req       = '0;
    logic o_req_ready;
    logic o_res_valid;
    t_res o_res;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;

    logic [SET_IDX_W-1:0] hot_sets [4];
    logic [TAG_IN_W-1:0]  tag_pool [12];

    plru_scoreboard sb = new();

    tree_plru_replacement dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_res       (o_res)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_res_ready <= (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid && i_res_ready) begin
            sb.check_result(o_res);
        end
    end

    // The request is noted on the edge that accepts it, in this same process,
    // so the expectation is queued before the end-of-run drain looks at it.
    task automatic send_request(input t_req req);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_req_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req       <= req;
        @(posedge i_clk);
        while (!o_req_ready) begin
            @(posedge i_clk);
        end
        sb.note_request(req);
    endtask

    function automatic t_req make_request(t_func func, int set, logic [TAG_IN_W-1:0] tag);
        t_req req;
        req.func      = func;
        req.set_index = SET_IDX_W'(set);
        req.tag_value = tag;
        return req;
    endfunction

    // A few busy sets and a small tag pool keep sets filling up, hitting and
    // emptying; the rest spreads over all sets and the full tag range.
    function automatic t_req random_request();
        t_req req;
        int   pick;
        pick = $urandom_range(99);
        if (pick < 35) begin
            req.func = FN_ACCESS;
        end else if (pick < 65) begin
            req.func = FN_INSERT;
        end else if (pick < 85) begin
            req.func = FN_EVICT;
        end else begin
            req.func = FN_PEEK;
        end
        req.set_index = ($urandom_range(99) < 80) ? hot_sets[$urandom_range(3)]
                                                  : SET_IDX_W'($urandom_range(63));
        req.tag_value = ($urandom_range(99) < 75) ? tag_pool[$urandom_range(11)]
                                                  : TAG_IN_W'($urandom);
        return req;
    endfunction

    task automatic refresh_pools();
        foreach (hot_sets[i]) begin
            hot_sets[i] = SET_IDX_W'($urandom_range(63));
        end
        foreach (tag_pool[i]) begin
            tag_pool[i] = TAG_IN_W'($urandom);
        end
    endtask

    task automatic run_random(input int count);
        refresh_pools();
        repeat (count) begin
            send_request(random_request());
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        tx_idle_pct = 29;
        rx_idle_pct = 77;

        // Empty victims, a miss, then a set filled to the brim with a duplicate tag.
        send_request(make_request(FN_PEEK,   0,  20'h00000));
        send_request(make_request(FN_EVICT,  63, 20'hFFFFF));
        send_request(make_request(FN_ACCESS, 0,  20'h00000));
        send_request(make_request(FN_INSERT, 0,  20'h00000));
        send_request(make_request(FN_INSERT, 0,  20'hFFFFF));
        send_request(make_request(FN_INSERT, 0,  20'hFFFFF));
        send_request(make_request(FN_INSERT, 0,  20'h11111));
        send_request(make_request(FN_INSERT, 0,  20'h22222));
        send_request(make_request(FN_INSERT, 0,  20'h33333));
        send_request(make_request(FN_INSERT, 0,  20'h44444));
        send_request(make_request(FN_INSERT, 0,  20'h55555));
        send_request(make_request(FN_INSERT, 0,  20'h66666));
        send_request(make_request(FN_ACCESS, 0,  20'hFFFFF));
        send_request(make_request(FN_ACCESS, 0,  20'h00000));
        send_request(make_request(FN_PEEK,   0,  20'h00000));
        send_request(make_request(FN_EVICT,  0,  20'h00000));
        send_request(make_request(FN_EVICT,  0,  20'h00000));
        send_request(make_request(FN_INSERT, 0,  20'h77777));
        send_request(make_request(FN_ACCESS, 0,  20'h12345));
        send_request(make_request(FN_INSERT, 63, 20'hABCDE));
        send_request(make_request(FN_PEEK,   63, 20'h00000));
        send_request(make_request(FN_EVICT,  63, 20'h00000));
        send_request(make_request(FN_EVICT,  63, 20'h00000));

        run_random(430);

        tx_idle_pct = 77;
        rx_idle_pct = 29;
        run_random(430);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random(440);

        i_req_valid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);

        if (sb.error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
